// ----- src/mstw_pkg.sv -----
// shared types and constants for the minimum spanning tree weight block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mstw_pkg;

   localparam int MSTW_MAX_VERTICES = 256;
   localparam int MSTW_MAX_EDGES    = 1024;

   localparam int MSTW_VERTEX_W = 8;
   localparam int MSTW_LENGTH_W = 16;
   localparam int MSTW_SUM_W    = 26;
   localparam int MSTW_RANK_W   = 4;

   localparam logic [MSTW_RANK_W-1:0] MSTW_RANK_MAX = '1;

   // request from the sequencer to the union-find unit
   typedef struct packed {
      logic clear;
      logic link;
   } mstw_uf_req_type;

   // reply from the union-find unit
   typedef struct packed {
      logic done;
      logic joined;
   } mstw_uf_rsp_type;

endpackage

`default_nettype wire

// ----- src/mstw_union_find.sv -----
// union-find forest with union by rank over a parent/rank memory with one read and one write port
// depends on mstw_pkg
`timescale 1ns / 1ps
`default_nettype none

module mstw_union_find
   import mstw_pkg::*;
#(
   parameter int MAX_VERTICES = MSTW_MAX_VERTICES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mstw_uf_req_type          uf_req_i,
   input  wire logic [MSTW_VERTEX_W-1:0] vertex_a_i,
   input  wire logic [MSTW_VERTEX_W-1:0] vertex_b_i,
   output mstw_uf_rsp_type               uf_rsp_o
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int XW = (VW > MSTW_VERTEX_W) ? VW : MSTW_VERTEX_W;
   localparam logic [XW:0]   MV_C   = (XW+1)'(MAX_VERTICES);
   localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

   typedef enum logic [3:0] {
      U_IDLE, U_CLR, U_RA, U_RB, U_FA, U_FA_CHK, U_FB, U_FB_CHK, U_LINK, U_BUMP
   } state_type;

   state_type                     state_ff;
   logic [VW-1:0]                 ptr_ff;
   logic [XW-1:0]                 xa_ff, xb_ff;
   logic [VW-1:0]                 ra_ff, rb_ff;
   logic [MSTW_RANK_W-1:0]        rka_ff, rkb_ff;
   mstw_uf_rsp_type               rsp_ff;

   logic [MSTW_RANK_W+VW-1:0]     node_mem_ff [MAX_VERTICES];
   logic [MSTW_RANK_W+VW-1:0]     node_q_ff;
   logic [VW-1:0]                 q_parent;
   logic [MSTW_RANK_W-1:0]        q_rank;

   logic                          wr_en;
   logic [VW-1:0]                 wr_addr;
   logic [MSTW_RANK_W+VW-1:0]     wr_data;
   logic [VW-1:0]                 rd_addr;

   assign q_parent = node_q_ff[VW-1:0];
   assign q_rank   = node_q_ff[MSTW_RANK_W+VW-1:VW];
   assign uf_rsp_o = rsp_ff;

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ra_ff;
      wr_data = {rka_ff, rb_ff};
      rd_addr = (state_ff == U_FB) ? xb_ff[VW-1:0] : xa_ff[VW-1:0];
      unique case (state_ff)
         U_CLR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = {{MSTW_RANK_W{1'b0}}, ptr_ff};
         end
         U_LINK: begin
            if (ra_ff != rb_ff) begin
               wr_en = 1'b1;
               if (rka_ff >= rkb_ff) begin
                  wr_addr = rb_ff;
                  wr_data = {rkb_ff, ra_ff};
               end else begin
                  wr_addr = ra_ff;
                  wr_data = {rka_ff, rb_ff};
               end
            end
         end
         U_BUMP: begin
            wr_en   = 1'b1;
            wr_addr = ra_ff;
            wr_data = {rka_ff + 1'b1, ra_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      node_q_ff <= node_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         rsp_ff   <= '0;
      end else begin
         rsp_ff <= '0;
         unique case (state_ff)
            U_IDLE: begin
               if (uf_req_i.clear) begin
                  ptr_ff   <= '0;
                  state_ff <= U_CLR;
               end else if (uf_req_i.link) begin
                  xa_ff    <= XW'(vertex_a_i);
                  xb_ff    <= XW'(vertex_b_i);
                  state_ff <= U_RA;
               end
            end
            U_CLR: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == LAST_V) begin
                  rsp_ff.done <= 1'b1;
                  state_ff    <= U_IDLE;
               end
            end
            // fold out-of-range indices back into the vertex range
            U_RA: begin
               if ({1'b0, xa_ff} >= MV_C) begin
                  xa_ff <= XW'({1'b0, xa_ff} - MV_C);
               end else begin
                  state_ff <= U_RB;
               end
            end
            U_RB: begin
               if ({1'b0, xb_ff} >= MV_C) begin
                  xb_ff <= XW'({1'b0, xb_ff} - MV_C);
               end else begin
                  state_ff <= U_FA;
               end
            end
            U_FA: begin
               state_ff <= U_FA_CHK;
            end
            U_FA_CHK: begin
               if (q_parent == xa_ff[VW-1:0]) begin
                  ra_ff    <= q_parent;
                  rka_ff   <= q_rank;
                  state_ff <= U_FB;
               end else begin
                  xa_ff    <= XW'(q_parent);
                  state_ff <= U_FA;
               end
            end
            U_FB: begin
               state_ff <= U_FB_CHK;
            end
            U_FB_CHK: begin
               if (q_parent == xb_ff[VW-1:0]) begin
                  rb_ff    <= q_parent;
                  rkb_ff   <= q_rank;
                  state_ff <= U_LINK;
               end else begin
                  xb_ff    <= XW'(q_parent);
                  state_ff <= U_FB;
               end
            end
            U_LINK: begin
               if (ra_ff == rb_ff) begin
                  rsp_ff.done <= 1'b1;
                  state_ff    <= U_IDLE;
               end else if (rka_ff == rkb_ff && rka_ff != MSTW_RANK_MAX) begin
                  state_ff <= U_BUMP;
               end else begin
                  rsp_ff.done   <= 1'b1;
                  rsp_ff.joined <= 1'b1;
                  state_ff      <= U_IDLE;
               end
            end
            U_BUMP: begin
               rsp_ff.done   <= 1'b1;
               rsp_ff.joined <= 1'b1;
               state_ff      <= U_IDLE;
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   a_joined_with_done: assert property (@(posedge clock) disable iff (reset)
      uf_rsp_o.joined |-> uf_rsp_o.done)
      else $error("joined reported without done");

   a_req_only_idle: assert property (@(posedge clock) disable iff (reset)
      (uf_req_i.link || uf_req_i.clear) |-> state_ff == U_IDLE)
      else $error("union-find request while busy");

   a_bump_below_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == U_BUMP |-> (rka_ff != MSTW_RANK_MAX && rka_ff == rkb_ff))
      else $error("rank increment on saturated or unequal rank");

   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_LINK && ra_ff != rb_ff) |=> $past(wr_en))
      else $error("distinct roots not linked");

endmodule

`default_nettype wire

// ----- src/min_spanning_tree_weight.sv -----
// top level: edge store, sorted-order edge selection scan and result register
// depends on mstw_pkg and mstw_union_find
//
// channel  direction  fields                                         handshake
// req      in         from_vertex, to_vertex, edge_length, last_edge  req_valid / req_stall
// rsp      out        total_length, overflow                         rsp_valid / rsp_stall
//
// edges load at one transfer per cycle while idle; req_stall is high from the last edge
// until its result has been taken
// after the last edge the forest is cleared; then, for each of the n stored edges in
// rising (length, arrival) order, a scan through the edge memory port selects it and a
// union-find pass links its ends; a final scan that finds no edge raises rsp_valid
// synchronous active-high reset clears control state; memories need no reset
// rsp holds its payload while rsp_valid is high and rsp_stall is high
`timescale 1ns / 1ps
`default_nettype none

module min_spanning_tree_weight
   import mstw_pkg::*;
#(
   parameter int MAX_VERTICES = MSTW_MAX_VERTICES,
   parameter int MAX_EDGES    = MSTW_MAX_EDGES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [MSTW_VERTEX_W-1:0]        req_from_vertex,
   input  wire logic [MSTW_VERTEX_W-1:0]        req_to_vertex,
   input  wire logic signed [MSTW_LENGTH_W-1:0] req_edge_length,
   input  wire logic                            req_last_edge,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [MSTW_SUM_W-1:0]         rsp_total_length,
   output logic                                 rsp_overflow
);

   localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int DW  = 2*MSTW_VERTEX_W + MSTW_LENGTH_W;
   localparam logic [CW-1:0] MAX_E_C = CW'(MAX_EDGES);

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_SCAN, S_EVAL, S_LINK, S_RESP
   } state_type;

   state_type                      state_ff;
   logic [CW-1:0]                  count_ff;
   logic                           drop_ff;
   logic signed [MSTW_SUM_W-1:0]   sum_ff;
   logic                           rsp_valid_ff;

   // edge store
   logic [DW-1:0]                  edge_mem_ff [MAX_EDGES];
   logic [DW-1:0]                  edge_q_ff;
   logic                           edge_wr;

   // selection scan: next edge in (length, arrival) order after the previous one
   logic [CW-1:0]                  scan_ff;
   logic                           cmp_vld_ff;
   logic [EIW-1:0]                 cmp_idx_ff;
   logic                           prev_vld_ff;
   logic signed [MSTW_LENGTH_W-1:0] prev_len_ff;
   logic [EIW-1:0]                 prev_idx_ff;
   logic                           best_vld_ff;
   logic signed [MSTW_LENGTH_W-1:0] best_len_ff;
   logic [EIW-1:0]                 best_idx_ff;
   logic [MSTW_VERTEX_W-1:0]       best_from_ff, best_to_ff;

   logic                           issue;
   logic signed [MSTW_LENGTH_W-1:0] cand_len;
   logic                           after_prev, before_best;
   logic signed [MSTW_SUM_W:0]     sum_wide;

   mstw_uf_req_type                uf_req_ff;
   mstw_uf_rsp_type                uf_rsp;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_length = sum_ff;
   assign rsp_overflow     = drop_ff;

   assign edge_wr = req_valid && !req_stall && (count_ff < MAX_E_C);
   assign issue   = (scan_ff < count_ff);

   assign cand_len    = edge_q_ff[MSTW_LENGTH_W-1:0];
   assign after_prev  = !prev_vld_ff || (cand_len > prev_len_ff)
                        || (cand_len == prev_len_ff && cmp_idx_ff > prev_idx_ff);
   assign before_best = !best_vld_ff || (cand_len < best_len_ff)
                        || (cand_len == best_len_ff && cmp_idx_ff < best_idx_ff);

   // saturating accumulate of the chosen edge length
   assign sum_wide = {sum_ff[MSTW_SUM_W-1], sum_ff}
                   + {{(MSTW_SUM_W+1-MSTW_LENGTH_W){best_len_ff[MSTW_LENGTH_W-1]}},
                      best_len_ff};

   always_ff @(posedge clock) begin
      if (edge_wr) begin
         edge_mem_ff[count_ff[EIW-1:0]] <=
            {req_from_vertex, req_to_vertex, req_edge_length};
      end
      edge_q_ff <= edge_mem_ff[scan_ff[EIW-1:0]];
   end

   mstw_union_find #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_uf (
      .clock      (clock),
      .reset      (reset),
      .uf_req_i   (uf_req_ff),
      .vertex_a_i (best_from_ff),
      .vertex_b_i (best_to_ff),
      .uf_rsp_o   (uf_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         uf_req_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         prev_vld_ff  <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         uf_req_ff <= '0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (count_ff < MAX_E_C) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_last_edge) begin
                     sum_ff          <= '0;
                     uf_req_ff.clear <= 1'b1;
                     state_ff        <= S_CLEAR;
                  end
               end
            end
            S_CLEAR: begin
               if (uf_rsp.done) begin
                  scan_ff     <= '0;
                  cmp_vld_ff  <= 1'b0;
                  prev_vld_ff <= 1'b0;
                  best_vld_ff <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               cmp_vld_ff <= issue;
               cmp_idx_ff <= scan_ff[EIW-1:0];
               if (issue) begin
                  scan_ff <= scan_ff + 1'b1;
               end
               if (cmp_vld_ff && after_prev && before_best) begin
                  best_vld_ff  <= 1'b1;
                  best_len_ff  <= cand_len;
                  best_idx_ff  <= cmp_idx_ff;
                  best_from_ff <= edge_q_ff[DW-1:DW-MSTW_VERTEX_W];
                  best_to_ff   <= edge_q_ff[MSTW_LENGTH_W+MSTW_VERTEX_W-1:MSTW_LENGTH_W];
               end
               if (!issue && !cmp_vld_ff) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (best_vld_ff) begin
                  uf_req_ff.link <= 1'b1;
                  state_ff       <= S_LINK;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end
            end
            S_LINK: begin
               if (uf_rsp.done) begin
                  if (uf_rsp.joined) begin
                     if (sum_wide[MSTW_SUM_W] != sum_wide[MSTW_SUM_W-1]) begin
                        sum_ff <= sum_wide[MSTW_SUM_W]
                                  ? {1'b1, {(MSTW_SUM_W-1){1'b0}}}
                                  : {1'b0, {(MSTW_SUM_W-1){1'b1}}};
                     end else begin
                        sum_ff <= sum_wide[MSTW_SUM_W-1:0];
                     end
                  end
                  prev_vld_ff <= 1'b1;
                  prev_len_ff <= best_len_ff;
                  prev_idx_ff <= best_idx_ff;
                  best_vld_ff <= 1'b0;
                  scan_ff     <= '0;
                  cmp_vld_ff  <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  count_ff     <= '0;
                  drop_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_E_C)
      else $error("edge count beyond store depth");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_edge) |=> req_stall)
      else $error("input not stalled after last edge");

   a_rsp_only_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_RESP && !prev_vld_ff == (count_ff == '0)))
      else $error("result shown outside response state or without edges");

   a_link_has_edge: assert property (@(posedge clock) disable iff (reset)
      uf_req_ff.link |-> (best_vld_ff && state_ff == S_LINK))
      else $error("union request without a selected edge");

endmodule

`default_nettype wire
